// File: rtl/round_robin_thread_scheduler_assert.svh
// Assertion macros shared by the round-robin thread scheduler modules.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg)
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/rrts_pkg.sv
// Types, constants and helper functions of the round-robin thread scheduler.
package rrts_pkg;

  localparam int MAX_THREADS_DEF = 32;
  localparam int MASK_W          = 32;
  localparam int CNT_W           = 6;
  localparam int TICKS_W         = 32;
  localparam int REQ_W           = 2;

  // Request codes carried on in_tuser
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELAY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SCHED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_END,
    ST_SCAN_CHK,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic cfg_wr;
    logic tick_rd;
    logic pick_idle;
    logic scan_step;
    logic load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             run_zero;
    logic             cnt_one;
    logic             last_walk;
    logic             none_ready;
    logic             hit;
    logic             out_free;
  } dp_sts_t;

  // Clamp a raw thread count into 1..cmax
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw,
                                                 input logic [CNT_W-1:0] cmax);
    logic [CNT_W-1:0] c;
    c = raw;
    if (c == '0) c = CNT_W'(1);
    if (c > cmax) c = cmax;
    return c;
  endfunction

  // Bit k set when thread k+1 is started under count cnt
  function automatic logic [MASK_W-1:0] started_mask(input logic [CNT_W-1:0] cnt);
    logic [MASK_W-1:0] m;
    for (int k = 0; k < MASK_W; k++) begin
      m[k] = (CNT_W'(k + 1) < cnt);
    end
    return m;
  endfunction

endpackage

// File: rtl/rrts_dp.sv
// Datapath of the thread scheduler: ready bits, sleep counter memory, scan and result register.
module rrts_dp #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rrts_pkg::dp_cmd_t               cmd,
  output rrts_pkg::dp_sts_t               sts,
  input  logic [rrts_pkg::CNT_W-1:0]      cfg_data,
  input  logic [rrts_pkg::REQ_W-1:0]      in_req,
  input  logic [rrts_pkg::TICKS_W-1:0]    in_ticks,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata
);

  localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam logic [rrts_pkg::CNT_W-1:0] CNT_MAX = rrts_pkg::CNT_W'(MAX_THREADS + 1);

  logic [rrts_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MAX_THREADS-1:0]       ready_r, ready_nxt;
  logic [MAX_THREADS-1:0]       vld_r, vld_nxt;
  logic [rrts_pkg::CNT_W-1:0]   run_r, run_nxt;
  logic [rrts_pkg::CNT_W-1:0]   prev_r;
  logic [rrts_pkg::CNT_W-1:0]   scan_r;
  logic                         refused_r;
  logic [AW-1:0]                walk_r;
  logic [AW-1:0]                upd_addr_r;
  logic                         upd_v_r;
  logic [rrts_pkg::TICKS_W-1:0] rd_data_r;
  logic                         rd_vld_r;
  logic                         out_v_r;
  logic [39:0]                  out_data_r;
  logic [rrts_pkg::TICKS_W-1:0] mem [MAX_THREADS];

  logic [rrts_pkg::CNT_W-1:0]   new_cnt, min_cnt, cand, run_m1, cand_m1;
  logic [rrts_pkg::MASK_W-1:0]  sm_cur_w, sm_new_w, sm_min_w;
  logic [MAX_THREADS-1:0]       sm_cur, sm_new, sm_min;
  logic                         delay_wr, tick_wr, wr_en;
  logic [AW-1:0]                wr_addr;
  logic [rrts_pkg::TICKS_W-1:0] wr_data;

  // Count arithmetic and started masks
  assign new_cnt  = rrts_pkg::eff_count(cfg_data, CNT_MAX);
  assign min_cnt  = (new_cnt < cnt_r) ? new_cnt : cnt_r;
  assign sm_cur_w = rrts_pkg::started_mask(cnt_r);
  assign sm_new_w = rrts_pkg::started_mask(new_cnt);
  assign sm_min_w = rrts_pkg::started_mask(min_cnt);
  assign sm_cur   = sm_cur_w[MAX_THREADS-1:0];
  assign sm_new   = sm_new_w[MAX_THREADS-1:0];
  assign sm_min   = sm_min_w[MAX_THREADS-1:0];

  // Round-robin candidate after the scan pointer
  always_comb begin
    cand = scan_r + rrts_pkg::CNT_W'(1);
    if (cand >= cnt_r) cand = rrts_pkg::CNT_W'(1);
  end
  assign cand_m1 = cand - rrts_pkg::CNT_W'(1);
  assign run_m1  = run_r - rrts_pkg::CNT_W'(1);

  // Memory write sources: a delay at accept, or a tick decrement
  assign delay_wr = cmd.accept && (in_req == rrts_pkg::REQ_DELAY) && (run_r != '0);
  assign tick_wr  = upd_v_r && rd_vld_r && (rd_data_r != '0);
  assign wr_en    = delay_wr || tick_wr;
  assign wr_addr  = delay_wr ? run_m1[AW-1:0] : upd_addr_r;
  assign wr_data  = delay_wr ? in_ticks : (rd_data_r - rrts_pkg::TICKS_W'(1));

  // Sleep counter memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.tick_rd) begin
      rd_data_r <= mem[walk_r];
    end
  end

  // Ready bits and entry valid bits
  always_comb begin
    ready_nxt = ready_r;
    vld_nxt   = vld_r;
    priority if (cmd.cfg_wr) begin
      ready_nxt = (ready_r & sm_new) | (sm_new & ~sm_cur);
      vld_nxt   = vld_r & sm_min;
    end else if (delay_wr) begin
      ready_nxt[run_m1[AW-1:0]] = 1'b0;
      vld_nxt[run_m1[AW-1:0]]   = 1'b1;
    end else if (tick_wr && (rd_data_r == rrts_pkg::TICKS_W'(1))) begin
      ready_nxt[upd_addr_r] = 1'b1;
    end
  end

  // Running index
  always_comb begin
    run_nxt = run_r;
    priority if (cmd.cfg_wr) begin
      if (run_r >= new_cnt) run_nxt = '0;
    end else if (cmd.pick_idle) begin
      run_nxt = '0;
    end else if (cmd.scan_step && sts.hit) begin
      run_nxt = cand;
    end
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= rrts_pkg::CNT_W'(1);
      ready_r <= '0;
      vld_r   <= '0;
      run_r   <= '0;
      upd_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cmd.cfg_wr) cnt_r <= new_cnt;
      ready_r <= ready_nxt;
      vld_r   <= vld_nxt;
      run_r   <= run_nxt;
      upd_v_r <= cmd.tick_rd;
      if (cmd.load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Per-transaction working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prev_r    <= run_r;
      scan_r    <= run_r;
      refused_r <= (in_req == rrts_pkg::REQ_DELAY) && (run_r == '0);
      walk_r    <= '0;
    end else begin
      if (cmd.scan_step) scan_r <= cand;
      if (cmd.tick_rd) walk_r <= walk_r + AW'(1);
    end
    if (cmd.tick_rd) begin
      upd_addr_r <= walk_r;
      rd_vld_r   <= vld_r[walk_r];
    end
    if (cmd.load) begin
      out_data_r <= {rrts_pkg::MASK_W'(ready_r), refused_r, (run_r != prev_r), run_r};
    end
  end

  // Status to the controller
  assign sts.req        = in_req;
  assign sts.run_zero   = (run_r == '0);
  assign sts.cnt_one    = (cnt_r == rrts_pkg::CNT_W'(1));
  assign sts.last_walk  = (rrts_pkg::CNT_W'(walk_r) == (cnt_r - rrts_pkg::CNT_W'(2)));
  assign sts.none_ready = ((ready_r & sm_cur) == '0);
  assign sts.hit        = ready_r[cand_m1[AW-1:0]];
  assign sts.out_free   = !out_v_r || out_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

`include "round_robin_thread_scheduler_assert.svh"
  `RRTS_ASSERT_IMP(a_ready_started, 1'b1, (ready_r & ~sm_cur) == '0, "ready bit outside started threads")
  `RRTS_ASSERT_IMP(a_run_in_range, 1'b1, run_r < cnt_r, "running index not started")
  `RRTS_ASSERT_IMP(a_load_free, cmd.load, !out_v_r || out_tready, "result register overwritten")

endmodule

// File: rtl/rrts_ctrl.sv
// Controller state machine of the thread scheduler.
module rrts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  rrts_pkg::dp_sts_t sts,
  output rrts_pkg::dp_cmd_t cmd
);

  rrts_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign accept = (state_r == rrts_pkg::ST_IDLE) && in_tvalid && !cfg_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (sts.req)
            rrts_pkg::REQ_TICK:
              state_nxt = sts.cnt_one ? rrts_pkg::ST_FINISH : rrts_pkg::ST_TICK_RD;
            rrts_pkg::REQ_DELAY:
              state_nxt = sts.run_zero ? rrts_pkg::ST_FINISH : rrts_pkg::ST_SCAN_CHK;
            rrts_pkg::REQ_SCHED:
              state_nxt = rrts_pkg::ST_SCAN_CHK;
            default:
              state_nxt = rrts_pkg::ST_FINISH;
          endcase
        end
      end
      rrts_pkg::ST_TICK_RD: begin
        if (sts.last_walk) state_nxt = rrts_pkg::ST_TICK_END;
      end
      rrts_pkg::ST_TICK_END: begin
        state_nxt = rrts_pkg::ST_FINISH;
      end
      rrts_pkg::ST_SCAN_CHK: begin
        state_nxt = sts.none_ready ? rrts_pkg::ST_FINISH : rrts_pkg::ST_SCAN;
      end
      rrts_pkg::ST_SCAN: begin
        if (sts.hit) state_nxt = rrts_pkg::ST_FINISH;
      end
      rrts_pkg::ST_FINISH: begin
        if (sts.out_free) state_nxt = rrts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and handshakes
  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.cfg_wr    = (state_r == rrts_pkg::ST_IDLE) && cfg_valid;
    cmd.tick_rd   = (state_r == rrts_pkg::ST_TICK_RD);
    cmd.pick_idle = (state_r == rrts_pkg::ST_SCAN_CHK) && sts.none_ready;
    cmd.scan_step = (state_r == rrts_pkg::ST_SCAN);
    cmd.load      = (state_r == rrts_pkg::ST_FINISH) && sts.out_free;
    in_tready     = (state_r == rrts_pkg::ST_IDLE) && !cfg_valid;
    cfg_ready     = (state_r == rrts_pkg::ST_IDLE);
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "round_robin_thread_scheduler_assert.svh"
  `RRTS_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second transaction taken while busy")

endmodule

// File: rtl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler.
// Input stream: in_tuser carries the request (tick, delay, schedule), in_tdata the
// delay length in ticks. Each request yields one result on the output stream:
// chosen thread, switch flag, refused flag and the ready mask after the request.
// cfg_data sets the started thread count (idle thread included); write it only
// while no request is in flight. A config write is taken ahead of a request.
// Request handling, with N the effective thread count:
//   tick: one sleep counter per cycle (threads 1 to N-1) is read through the counter
//   memory, then the pipeline drains and the result loads; no walk when N is 1.
//   schedule or delay: the one-thread-per-cycle round-robin scan, then the result load.
//   refused delay or unused code: straight to the result load.
// One request is in flight at a time; the result register frees the core, so a
// new request can be taken while the previous result waits on out_tready. A
// stalled receiver holds the result and only blocks the next result load.
// Reset (synchronous, rst_n low): count 1, no thread ready, all counter entries
// marked invalid, idle thread running; no clearing pass is needed.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,   // thread_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] delay_ticks
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [5:0] next_thread, [6] switch_needed,
                                  // [7] delay_refused, [39:8] ready_mask
);

  rrts_pkg::dp_cmd_t cmd;
  rrts_pkg::dp_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_data   (cfg_data),
    .in_req     (in_tuser),
    .in_ticks   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: bench/rrts_checker.sv
// Checker for the round-robin thread scheduler: tracks the channels and checks each result.
`timescale 1ns / 1ps

module rrts_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  // One result transaction, members from the top bit down
  typedef struct packed {
    logic [rrts_pkg::MASK_W-1:0] ready;
    logic                        refused;
    logic                        switched;
    logic [rrts_pkg::CNT_W-1:0]  thread;
  } sched_result_t;

  logic [rrts_pkg::MASK_W-1:0]  ready_bits_m;
  logic [rrts_pkg::TICKS_W-1:0] sleep_left [rrts_pkg::MAX_THREADS_DEF];
  int                           run_idx;
  logic [rrts_pkg::CNT_W-1:0]   count_raw;
  sched_result_t                expected_q [$];
  sched_result_t                got, want;

  // Started thread count, idle thread included, clamped to 1..MAX+1
  function automatic int active_threads();
    int c;
    c = count_raw;
    if (c < 1) c = 1;
    if (c > rrts_pkg::MAX_THREADS_DEF + 1) c = rrts_pkg::MAX_THREADS_DEF + 1;
    return c;
  endfunction

  // Bit k set when thread k+1 is started
  function automatic logic [rrts_pkg::MASK_W-1:0] live_mask(input int cnt);
    logic [rrts_pkg::MASK_W-1:0] m;
    for (int k = 0; k < rrts_pkg::MASK_W; k++) m[k] = (k + 1 < cnt);
    return m;
  endfunction

  // Next ready thread after the running one, wrapping past the idle thread
  function automatic int next_runnable(input int cnt);
    int idx;
    if ((ready_bits_m & live_mask(cnt)) == '0) return 0;
    idx = run_idx;
    for (int i = 0; i < cnt; i++) begin
      idx++;
      if (idx >= cnt) idx = 1;
      if (ready_bits_m[idx-1]) return idx;
    end
    return 0;
  endfunction

  function automatic void reset_model();
    count_raw    = rrts_pkg::CNT_W'(1);
    ready_bits_m = '0;
    run_idx      = 0;
    for (int k = 0; k < rrts_pkg::MAX_THREADS_DEF; k++) sleep_left[k] = '0;
  endfunction

  // Start newly counted threads ready, clear the ones dropped
  function automatic void apply_count(input logic [rrts_pkg::CNT_W-1:0] value);
    int oldc, newc;
    oldc = active_threads();
    count_raw = value;
    newc = active_threads();
    for (int n = 1; n <= rrts_pkg::MAX_THREADS_DEF; n++) begin
      if (n >= newc) begin
        ready_bits_m[n-1] = 1'b0;
        sleep_left[n-1]   = '0;
      end else if (n >= oldc) begin
        ready_bits_m[n-1] = 1'b1;
        sleep_left[n-1]   = '0;
      end
    end
    if (run_idx >= newc) run_idx = 0;
  endfunction

  // Advance the model by one request and return its result
  function automatic sched_result_t predict_request(
    input logic [rrts_pkg::REQ_W-1:0]   req,
    input logic [rrts_pkg::TICKS_W-1:0] ticks
  );
    sched_result_t r;
    int cnt, prev, nxt;
    cnt = active_threads();
    prev = run_idx;
    nxt = prev;
    r = '0;
    case (req)
      rrts_pkg::REQ_TICK: begin
        for (int n = 1; n < cnt; n++) begin
          if (sleep_left[n-1] != '0) begin
            sleep_left[n-1]--;
            if (sleep_left[n-1] == '0) ready_bits_m[n-1] = 1'b1;
          end
        end
      end
      rrts_pkg::REQ_DELAY: begin
        if (prev == 0 || prev >= cnt) begin
          r.refused = 1'b1;
        end else begin
          sleep_left[prev-1]   = ticks;
          ready_bits_m[prev-1] = 1'b0;
          nxt = next_runnable(cnt);
          run_idx = nxt;
          r.switched = (nxt != prev);
        end
      end
      rrts_pkg::REQ_SCHED: begin
        nxt = next_runnable(cnt);
        run_idx = nxt;
        r.switched = (nxt != prev);
      end
      default: ;
    endcase
    r.thread = rrts_pkg::CNT_W'(nxt);
    r.ready  = ready_bits_m;
    return r;
  endfunction

  // Track config, check results against the oldest prediction, queue new ones
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      expected_q.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_count(cfg_data);
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no request outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          got  = sched_result_t'(out_tdata);
          want = expected_q.pop_front();
          checked++;
          if (got.thread !== want.thread) begin
            $error("next_thread: expected %0d, actual %0d", want.thread, got.thread);
            fail_count++;
          end
          if (got.switched !== want.switched) begin
            $error("switch_needed: expected %0d, actual %0d", want.switched, got.switched);
            fail_count++;
          end
          if (got.refused !== want.refused) begin
            $error("delay_refused: expected %0d, actual %0d", want.refused, got.refused);
            fail_count++;
          end
          if (got.ready !== want.ready) begin
            $error("ready_mask: expected %h, actual %h", want.ready, got.ready);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) expected_q.push_back(predict_request(in_tuser, in_tdata));
    end
    pending = expected_q.size();
  end

endmodule

// File: bench/tb.sv
// Testbench top for the round-robin thread scheduler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

  localparam logic [rrts_pkg::REQ_W-1:0] REQ_UNUSED  = 2'd3;
  localparam int                         STALL_LIMIT = 3000;
  localparam int                         SEG_ITEMS   = 65;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  int fail_count, pending, checked;
  int in_gap_pct, out_stall_pct;
  int sent, cfg_writes, idle_cycles;

  round_robin_thread_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  rrts_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the receiver at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Send one request, with random gaps ahead of it; returns at the accepting edge
  task automatic push_request(input logic [rrts_pkg::REQ_W-1:0] req, input logic [31:0] ticks);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= ticks;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Drain all outstanding results, then write the thread count
  task automatic set_thread_count(input logic [5:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Sleep length: mostly short so ticks wake threads, sometimes zero or full range
  function automatic logic [31:0] pick_sleep();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 65) return $urandom_range(1, 6);
    if (r < 80) return $urandom_range(7, 40);
    return $urandom();
  endfunction

  task automatic random_segment(input logic [5:0] count_value);
    int r;
    set_thread_count(count_value);
    for (int i = 0; i < SEG_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 38)      push_request(rrts_pkg::REQ_TICK, $urandom());
      else if (r < 63) push_request(rrts_pkg::REQ_DELAY, pick_sleep());
      else if (r < 96) push_request(rrts_pkg::REQ_SCHED, $urandom());
      else             push_request(REQ_UNUSED, $urandom());
    end
  endtask

  initial begin
    logic [5:0] seg_counts [12];
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    in_gap_pct    = 24;
    out_stall_pct = 54;
    sent          = 0;
    cfg_writes    = 0;
    idle_cycles   = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset state: one thread, nothing ready, idle running
    push_request(rrts_pkg::REQ_SCHED, 32'd0);
    push_request(rrts_pkg::REQ_DELAY, 32'd5);
    push_request(rrts_pkg::REQ_TICK, 32'd0);
    push_request(REQ_UNUSED, 32'hFFFF_FFFF);

    // All 32 threads: walk through delays of zero, maximum and one tick
    set_thread_count(6'd33);
    push_request(rrts_pkg::REQ_SCHED, 32'd0);
    push_request(rrts_pkg::REQ_DELAY, 32'd0);
    push_request(rrts_pkg::REQ_DELAY, 32'hFFFF_FFFF);
    push_request(rrts_pkg::REQ_DELAY, 32'd1);
    push_request(rrts_pkg::REQ_TICK, 32'd0);
    push_request(rrts_pkg::REQ_SCHED, 32'd0);
    push_request(rrts_pkg::REQ_SCHED, 32'd0);

    // Shrink below the running thread, then run out of ready threads
    set_thread_count(6'd4);
    push_request(rrts_pkg::REQ_SCHED, 32'd0);
    push_request(rrts_pkg::REQ_DELAY, 32'd2);
    push_request(rrts_pkg::REQ_TICK, 32'd0);
    push_request(rrts_pkg::REQ_TICK, 32'd0);
    push_request(rrts_pkg::REQ_SCHED, 32'd0);

    // Count zero acts as one; count above range acts as the maximum
    set_thread_count(6'd0);
    push_request(rrts_pkg::REQ_SCHED, 32'd0);
    push_request(rrts_pkg::REQ_DELAY, 32'd7);
    set_thread_count(6'd63);
    push_request(rrts_pkg::REQ_SCHED, 32'd0);
    push_request(rrts_pkg::REQ_TICK, 32'd0);
    push_request(REQ_UNUSED, 32'd0);

    // Random segments, each under its own thread count
    seg_counts = '{6'd2, 6'd33, 6'd5, 6'd0, 6'd63, 6'd9, 6'd1, 6'd0, 6'd3, 6'd17, 6'd33, 6'd0};
    seg_counts[7]  = 6'($urandom_range(2, 12));
    seg_counts[11] = 6'($urandom_range(0, 63));
    for (int s = 0; s < 12; s++) begin
      if (s == 4) begin
        in_gap_pct    = 54;
        out_stall_pct = 24;
      end else if (s == 8) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      random_segment(seg_counts[s]);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d requests under %0d thread-count writes; %0d results checked.",
             sent, cfg_writes, checked);
    $display("Covered sender gaps, receiver stalls and back-to-back streaming.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_dp.sv
rtl/rrts_ctrl.sv
rtl/round_robin_thread_scheduler.sv
bench/rrts_checker.sv
bench/tb.sv
